// File: src/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  // queue entry from front to back: one classified byte operation
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } cmd_t;

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [255:0] H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic logic [31:0] sm_s0(input logic [31:0] x);
    sm_s0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sm_s1(input logic [31:0] x);
    sm_s1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

// File: src/sha_if.sv
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: src/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// Accepts items, drops ones with no effect, and queues the rest (4 deep).
// ----------------------------------------------------------------------------
module sha_front (
  input  logic          clk,
  input  logic          rst,
  sha_in_if.sink        in_ch,
  output logic          cmd_valid,
  output sha_pkg::cmd_t cmd,
  input  logic          cmd_take
);

  sha_pkg::cmd_t q [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       push;
  logic       acc;

  assign in_ch.ready = (count != 3'd4);
  assign acc  = in_ch.valid && in_ch.ready;
  // items with neither flag do nothing
  assign push = acc && (in_ch.byte_valid || in_ch.end_of_message);
  assign cmd_valid = (count != 3'd0);
  assign cmd = q[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{in_ch.data_byte, in_ch.byte_valid, in_ch.end_of_message};
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (cmd_take) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'd0, push} - {2'd0, cmd_take};
    end
  end

endmodule

// File: src/sha_back.sv
// ----------------------------------------------------------------------------
// sha_back
// Buffers bytes, pads, runs one compression round per cycle, emits digest.
// ----------------------------------------------------------------------------
module sha_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  sha_pkg::cmd_t cmd,
  output logic          cmd_take,
  sha_out_if.source     out_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]   state;
  logic [31:0]  buf_w [16];
  logic [60:0]  byte_count;
  logic [5:0]   pos;
  logic         pad_mode;
  logic         pad_last;
  logic [31:0]  w [16];
  logic [31:0]  v [8];
  logic [31:0]  h [8];
  logic [5:0]   round_index;
  logic [2:0]   out_idx;
  logic [63:0]  bits;
  logic [31:0]  w_new;
  logic [31:0]  w_cur;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [3:0]   slot;

  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign bits = {byte_count, 3'b000};
  assign slot = round_index[3:0];

  // message schedule word for this round
  always_comb begin
    w_new = w[slot] + sha_pkg::sm_s0(w[slot + 4'd1]) + w[slot + 4'd9]
          + sha_pkg::sm_s1(w[slot + 4'd14]);
    w_cur = (round_index < 6'd16) ? w[slot] : w_new;
    t1 = v[7] + sha_pkg::big_s1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
       + sha_pkg::K_TABLE[round_index] + w_cur;
    t2 = sha_pkg::big_s0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  assign out_ch.valid       = (state == S_OUT);
  assign out_ch.digest_word = h[out_idx];
  assign out_ch.word_index  = out_idx;
  assign out_ch.last_word   = (out_idx == 3'd7);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      byte_count <= '0;
      round_index <= '0;
      out_idx <= '0;
      pad_mode <= 1'b0;
      pad_last <= 1'b0;
      for (int i = 0; i < 8; i++) h[i] <= sha_pkg::H_INIT[255 - 32*i -: 32];
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.byte_valid) begin
              buf_w[pos[5:2]][8*(3 - pos[1:0]) +: 8] <= cmd.data_byte;
              byte_count <= byte_count + 61'd1;
              pad_last <= cmd.end_of_message;
              pad_mode <= 1'b0;
              if (pos == 6'd63) state <= S_LOAD;
              else if (cmd.end_of_message) state <= S_PAD;
            end else begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // pad byte, then zero up to a block end or length field
          for (int i = 0; i < 16; i++) begin
            for (int b = 0; b < 4; b++) begin
              if (6'(4*i + b) == pos) buf_w[i][8*(3-b) +: 8] <= sha_pkg::PAD_BYTE;
              else if (6'(4*i + b) > pos && !(i >= 14 && pos < sha_pkg::LEN_POS))
                buf_w[i][8*(3-b) +: 8] <= 8'h00;
            end
          end
          if (pos < sha_pkg::LEN_POS) begin
            buf_w[14] <= bits[63:32];
            buf_w[15] <= bits[31:0];
            pad_last <= 1'b1;
          end else begin
            pad_last <= 1'b0;
          end
          pad_mode <= 1'b1;
          state <= S_LOAD;
        end
        S_LOAD: begin
          for (int i = 0; i < 16; i++) w[i] <= buf_w[i];
          for (int i = 0; i < 8; i++) v[i] <= h[i];
          round_index <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          if (round_index >= 6'd16) w[slot] <= w_new;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          round_index <= round_index + 6'd1;
          if (round_index == 6'd63) state <= S_FIN;
        end
        S_FIN: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          round_index <= '0;
          if (!pad_mode) begin
            // full data block; pad now if the message ended here
            state <= pad_last ? S_PAD : S_IDLE;
          end else if (pad_last) begin
            out_idx <= '0;
            state <= S_OUT;
          end else begin
            // overflow block done; next block is zeros plus length
            for (int i = 0; i < 14; i++) buf_w[i] <= '0;
            buf_w[14] <= bits[63:32];
            buf_w[15] <= bits[31:0];
            pad_last <= 1'b1;
            state <= S_LOAD;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) h[i] <= sha_pkg::H_INIT[255 - 32*i -: 32];
              byte_count <= '0;
              pad_mode <= 1'b0;
              pad_last <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pos = byte_count[5:0];

endmodule

// File: src/sha256_message_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher_core
// SHA-256 over a byte stream with padding and digest word output.
// ----------------------------------------------------------------------------
// a byte item is accepted in the idle state; every 64th byte starts a block compression,
// one round per cycle in the back part's round unit
// end of message: a pad step, one or two compressed blocks, 8 output words
// a 4-entry queue parts front and back; sync reset restores initial hash
module sha256_message_hasher_core (
  input  logic      clk,
  input  logic      rst,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);

  logic          cmd_valid;
  logic          cmd_take;
  sha_pkg::cmd_t cmd;

  sha_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
  );

  sha_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_take(cmd_take), .out_ch(out_ch)
  );

endmodule

// File: verif/tb_sha256_message_hasher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_message_hasher_core
// Feeds byte items through the hasher and checks every digest word against
// a built-in SHA-256 predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_sha256_message_hasher_core;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  typedef struct {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        end_of_message;
    logic        has_known;
    logic [31:0] known_h0;
  } stim_row_t;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 300;
  localparam int ItemTarget = 380;

  logic clk;
  logic rst;
  sha_in_if in_ch ();
  sha_out_if out_ch ();

  sha256_message_hasher_core i_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // predictor state
  logic [31:0]  hash_state [8];
  logic [7:0]   msg_block [64];
  logic [60:0]  msg_bytes;
  digest_item_t digest_queue [$];
  logic [31:0]  known_h0_queue [$];
  logic         known_valid_queue [$];
  int           error_count;
  int           cycle_count;
  int           item_count;
  bit           in_calm;
  bit           out_calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void reset_hash_state();
    for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::H_INIT[255 - 32 * i -: 32];
    msg_bytes = '0;
  endfunction

  // one 64-round compression of msg_block into hash_state
  function automatic void compress_block();
    logic [31:0] sched [16];
    logic [31:0] v [8];
    logic [31:0] t1, t2, w15, w2;
    int slot;
    for (int i = 0; i < 16; i++)
      sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int r = 0; r < 64; r++) begin
      slot = r % 16;
      if (r >= 16) begin
        w15 = sched[(r - 15) % 16];
        w2 = sched[(r - 2) % 16];
        sched[slot] = sched[slot]
          + (rot_right(w15, 7) ^ rot_right(w15, 18) ^ (w15 >> 3))
          + sched[(r - 7) % 16]
          + (rot_right(w2, 17) ^ rot_right(w2, 19) ^ (w2 >> 10));
      end
      t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::K_TABLE[r] + sched[slot];
      t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endfunction

  // apply one accepted byte item, queue the digest words it produces
  function automatic void predict_digest(input logic [7:0] data_byte, input logic byte_valid,
                                         input logic end_of_message);
    int pos;
    logic [63:0] bit_len;
    digest_item_t word;
    if (byte_valid) begin
      msg_block[msg_bytes[5:0]] = data_byte;
      msg_bytes = msg_bytes + 1'b1;
      if (msg_bytes[5:0] == 6'd0) compress_block();
    end
    if (!end_of_message) return;
    pos = msg_bytes[5:0];
    msg_block[pos] = sha_pkg::PAD_BYTE;
    pos++;
    if (pos > sha_pkg::LEN_POS) begin
      while (pos < 64) begin
        msg_block[pos] = 8'h00;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < sha_pkg::LEN_POS) begin
      msg_block[pos] = 8'h00;
      pos++;
    end
    bit_len = {msg_bytes, 3'b000};
    for (int i = 0; i < 8; i++) msg_block[56 + i] = bit_len[63 - 8 * i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      word.digest_word = hash_state[i];
      word.word_index = 3'(i);
      word.last_word = (i == 7);
      digest_queue = {digest_queue, word};
    end
    reset_hash_state();
  endfunction

  // output side: random stall, compare against oldest expectation
  always @(posedge clk) begin
    digest_item_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (digest_queue.size() == 0) begin
          report_mismatch("digest word with nothing expected");
        end else begin
          want = digest_queue.pop_front();
          if (out_ch.digest_word !== want.digest_word)
            report_mismatch($sformatf("word %0d: got %08h want %08h", want.word_index,
                                      out_ch.digest_word, want.digest_word));
          if (out_ch.word_index !== want.word_index)
            report_mismatch($sformatf("word_index got %0d want %0d", out_ch.word_index,
                                      want.word_index));
          if (out_ch.last_word !== want.last_word)
            report_mismatch($sformatf("last_word got %0b want %0b", out_ch.last_word,
                                      want.last_word));
          // typed-in h0 for the directed rows
          if (want.word_index == 3'd0 && known_valid_queue.size() > 0) begin
            if (known_valid_queue.pop_front() && out_ch.digest_word !== known_h0_queue[0])
              report_mismatch($sformatf("known h0 got %08h want %08h", out_ch.digest_word,
                                        known_h0_queue[0]));
            void'(known_h0_queue.pop_front());
          end
        end
      end
      out_ch.ready <= out_calm ? 1'b1 : ($urandom_range(99) >= 37);
    end
  end

  // directed rows: special cases and extremes
  stim_row_t directed_rows [$];

  function automatic void add_row(input logic [7:0] b, input logic bv, input logic eom,
                                  input logic kn = 1'b0, input logic [31:0] h0 = '0);
    stim_row_t row;
    row.data_byte = b;
    row.byte_valid = bv;
    row.end_of_message = eom;
    row.has_known = kn;
    row.known_h0 = h0;
    directed_rows = {directed_rows, row};
  endfunction

  task automatic send_item(input logic [7:0] b, input logic bv, input logic eom);
    while (!in_calm && $urandom_range(99) < 37) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.byte_valid <= bv;
    in_ch.end_of_message <= eom;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    item_count++;
    predict_digest(b, bv, eom);
  endtask

  // random message: mostly well formed, short lengths, a few long ones
  task automatic send_message();
    int len;
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) len = $urandom_range(54, 66);
    else if (pick < 25) len = $urandom_range(100, 140);
    else len = $urandom_range(0, 12);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, 1'b0);
    end
    if (len > 0 && $urandom_range(1) == 1) send_item(8'($urandom), 1'b1, 1'b1);
    else send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int drain;
    int pad_lens [4];
    error_count = 0;
    cycle_count = 0;
    item_count = 0;
    in_calm = 1'b0;
    out_calm = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.byte_valid = 1'b0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready = 1'b0;
    reset_hash_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty message right after reset
    add_row(8'hff, 1'b0, 1'b1, 1'b1, 32'he3b0c442);
    // "abc" with the last byte on the end item
    add_row(8'h61, 1'b1, 1'b0);
    add_row(8'h62, 1'b1, 1'b0);
    add_row(8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf);
    // item with neither flag does nothing
    add_row(8'hff, 1'b0, 1'b0);
    add_row(8'h00, 1'b1, 1'b0);
    add_row(8'hff, 1'b1, 1'b0);
    add_row(8'h55, 1'b0, 1'b0);
    add_row(8'haa, 1'b1, 1'b1);
    add_row(8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].end_of_message) begin
        known_valid_queue = {known_valid_queue, directed_rows[i].has_known};
        known_h0_queue = {known_h0_queue, directed_rows[i].known_h0};
      end
      send_item(directed_rows[i].data_byte, directed_rows[i].byte_valid,
                directed_rows[i].end_of_message);
    end
    // padding boundaries: 55, 56, 63, 64 bytes
    pad_lens = '{55, 56, 63, 64};
    foreach (pad_lens[k]) begin
      for (int i = 0; i < pad_lens[k]; i++) send_item(8'($urandom), 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
    end

    // random part, with a calm stretch in the middle
    while (item_count < ItemTarget) begin
      in_calm = (item_count > 290 && item_count < 340);
      out_calm = in_calm;
      send_message();
      if ($urandom_range(99) < 5) send_item(8'($urandom), 1'b0, 1'b0);
    end
    in_calm = 1'b0;
    out_calm = 1'b0;
    in_ch.valid <= 1'b0;

    drain = 0;
    while (digest_queue.size() > 0) @(posedge clk);
    while (drain < DrainCycles) begin
      @(posedge clk);
      drain++;
    end
    if (error_count == 0 && digest_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// File: sha256_message_hasher_core.f
src/sha_pkg.sv
src/sha_if.sv
src/sha_front.sv
src/sha_back.sv
src/sha256_message_hasher_core.sv
verif/tb_sha256_message_hasher_core.sv
